>>> hw/rtl/sstv_vis_header_detector_assert.svh
// ----------------------------------------------------------------------------
// SSTV VIS header detector assertion macros
// Concurrent assertion wrappers; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef SSTV_VIS_HEADER_DETECTOR_ASSERT_SVH
`define SSTV_VIS_HEADER_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

`define SVHD_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("svhd assertion failed");

`define SVHD_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("svhd assertion failed");

`else

`define SVHD_ASSERT_IMP(name, clk, rst, ante, cons)

`define SVHD_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/svhd_pkg.sv
// ----------------------------------------------------------------------------
// SSTV VIS header detector package
// Widths, step codes, tolerance windows, shared types and helpers.
// ----------------------------------------------------------------------------
package svhd_pkg;

   localparam int TONE_W         = 19;
   localparam int CODE_W         = 7;
   localparam int BITS_W         = 8;
   localparam int SHIFT_W        = 16;
   localparam int DIFF_W         = TONE_W + 1;
   localparam int FREQ_FRAC_BITS = 4;
   localparam int HISTORY_DEPTH  = 45;
   localparam int TRIAD          = 3;
   localparam int NUM_CELLS      = HISTORY_DEPTH / TRIAD;
   localparam int NUM_PHASES     = 3;
   localparam int NUM_REFS       = 3;
   localparam int NUM_LANES      = NUM_PHASES * NUM_REFS;
   localparam int STEP_W         = 4;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 64;
   localparam int KNOWN_W        = 2 * CSR_DATA_W;

   typedef logic [TONE_W-1:0]        tone_type;
   typedef tone_type [TRIAD-1:0]     triad_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic [STEP_W-1:0]        step_type;
   typedef logic [CODE_W-1:0]        code_type;
   typedef logic [CSR_IDX_W-1:0]     csr_idx_type;

   localparam step_type STEP_FIRST     = step_type'(1);
   localparam step_type STEP_LEAD_LAST = step_type'(4);
   localparam step_type STEP_START     = step_type'(5);
   localparam step_type STEP_BIT_FIRST = step_type'(6);
   localparam step_type STEP_BIT_LAST  = step_type'(13);
   localparam step_type STEP_STOP      = step_type'(14);

   localparam csr_idx_type CSR_KNOWN_LOW  = csr_idx_type'(0);
   localparam csr_idx_type CSR_KNOWN_HIGH = csr_idx_type'(1);
   localparam csr_idx_type CSR_INV_PARITY = csr_idx_type'(2);

   localparam int HZ = 1 << FREQ_FRAC_BITS;

   localparam diff_type LEAD_LO  = diff_type'(-(25 * HZ));
   localparam diff_type LEAD_HI  = diff_type'(25 * HZ);
   localparam diff_type SYNC_LO  = diff_type'(-(725 * HZ));
   localparam diff_type SYNC_HI  = diff_type'(-(675 * HZ));
   localparam diff_type ZERO_LO  = diff_type'(-(625 * HZ));
   localparam diff_type ZERO_HI  = diff_type'(-(575 * HZ));
   localparam diff_type ONE_LO   = diff_type'(-(825 * HZ));
   localparam diff_type ONE_HI   = diff_type'(-(775 * HZ));
   localparam diff_type CENTER   = diff_type'(1900 * HZ);
   localparam diff_type ROUND_UP = diff_type'(HZ - 1);

   typedef struct packed {
      logic shift;
      logic rotate;
   } cell_ctl_type;

   typedef struct packed {
      logic     clear;
      logic     check;
      logic     judge;
      step_type step;
   } lane_ctl_type;

   function automatic logic in_open_range(diff_type d, diff_type lo, diff_type hi);
      return (d > lo) && (d < hi);
   endfunction

endpackage

>>> hw/rtl/svhd_req_if.sv
// ----------------------------------------------------------------------------
// SSTV VIS header detector request channel
// Valid/ready channel carrying one tone-frequency estimate per transaction.
// ----------------------------------------------------------------------------
interface svhd_req_if
   import svhd_pkg::*;
();
   logic     valid;
   logic     ready;
   logic     peak_valid;
   tone_type tone_freq;

   modport source (output valid, peak_valid, tone_freq, input ready);
   modport sink   (input valid, peak_valid, tone_freq, output ready);
endinterface

>>> hw/rtl/svhd_rsp_if.sv
// ----------------------------------------------------------------------------
// SSTV VIS header detector response channel
// Valid/ready channel carrying one detection result per transaction.
// ----------------------------------------------------------------------------
interface svhd_rsp_if
   import svhd_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic                      detected;
   code_type                  vis_code;
   logic signed [SHIFT_W-1:0] freq_shift;

   modport source (output valid, detected, vis_code, freq_shift, input ready);
   modport sink   (input valid, detected, vis_code, freq_shift, output ready);
endinterface

>>> hw/rtl/svhd_triad.sv
// ----------------------------------------------------------------------------
// SSTV VIS header detector history cell
// Holds three consecutive tones; shifts by one tone or rotates by a triad.
// ----------------------------------------------------------------------------
module svhd_triad
   import svhd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  triad_type    nbr_triad,
   input  tone_type     shift_in,
   output triad_type    triad
);

   triad_type triad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         triad_ff <= '0;
      end else if (ctl.shift) begin
         triad_ff <= {shift_in, triad_ff[2], triad_ff[1]};
      end else if (ctl.rotate) begin
         triad_ff <= nbr_triad;
      end
   end

   assign triad = triad_ff;

endmodule

>>> hw/rtl/svhd_lane.sv
// ----------------------------------------------------------------------------
// SSTV VIS header detector candidate lane
// Checks one phase/reference candidate, one tone per step, then judges it.
// ----------------------------------------------------------------------------
module svhd_lane
   import svhd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  lane_ctl_type       ctl,
   input  tone_type           tone,
   input  tone_type           ref_tone,
   input  logic [KNOWN_W-1:0] known_codes,
   input  code_type           inv_code,
   output logic               pass,
   output code_type           code
);

   logic              ok_ff;
   logic              ok_in;
   logic [BITS_W-1:0] bits_ff;
   logic [BITS_W-1:0] bits_in;
   logic              pass_ff;
   logic              pass_in;
   diff_type          diff;
   logic [2:0]        bit_idx;
   logic              parity;

   assign diff    = diff_type'({1'b0, tone}) - diff_type'({1'b0, ref_tone});
   assign bit_idx = 3'(ctl.step - STEP_BIT_FIRST);

   always_comb begin
      ok_in   = ok_ff;
      bits_in = bits_ff;
      if (ctl.step >= STEP_FIRST && ctl.step <= STEP_LEAD_LAST) begin
         ok_in = ok_ff & in_open_range(diff, LEAD_LO, LEAD_HI);
      end else if (ctl.step == STEP_START || ctl.step == STEP_STOP) begin
         ok_in = ok_ff & in_open_range(diff, SYNC_LO, SYNC_HI);
      end else if (ctl.step >= STEP_BIT_FIRST && ctl.step <= STEP_BIT_LAST) begin
         if (in_open_range(diff, ONE_LO, ONE_HI)) begin
            bits_in[bit_idx] = 1'b1;
         end else if (!in_open_range(diff, ZERO_LO, ZERO_HI)) begin
            ok_in = 1'b0;
         end
      end
   end

   assign parity  = ^bits_ff[CODE_W-1:0] ^ (bits_ff[CODE_W-1:0] == inv_code);
   assign pass_in = ok_ff && (parity == bits_ff[BITS_W-1])
                    && known_codes[bits_ff[CODE_W-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         ok_ff   <= 1'b0;
         pass_ff <= 1'b0;
         bits_ff <= '0;
      end else if (ctl.clear) begin
         ok_ff   <= 1'b1;
         pass_ff <= 1'b0;
         bits_ff <= '0;
      end else if (ctl.check) begin
         ok_ff   <= ok_in;
         bits_ff <= bits_in;
      end else if (ctl.judge) begin
         pass_ff <= pass_in;
      end
   end

   assign pass = pass_ff;
   assign code = bits_ff[CODE_W-1:0];

endmodule

>>> hw/rtl/sstv_vis_header_detector.sv
// ----------------------------------------------------------------------------
// SSTV VIS header detector
// Searches a 45-tone history for a calibration header tail and VIS code.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one tone estimate per transaction (peak_valid, tone_freq
//   in 1/16 Hz); with peak_valid low the newest stored tone is repeated.
//   rsp_ch returns exactly one result per request: detected, vis_code and
//   freq_shift (leader minus 1900 Hz, whole Hz); code and shift are zero
//   when nothing is detected.
//   csr_* writes the known-code mask halves and the inverted-parity code;
//   write only while no request is in flight.
//   Requests are accepted only in the idle state. Each search runs the
//   15-step rotation of the history cell chain past the nine candidate
//   lanes (reference and scan states), then judges and loads the result.
//   A stalled rsp_ch holds the result in its output register; one further
//   request is accepted and searched, then waits for that register.
//   Reset clears the history to zero, the csr registers to zero and the
//   output register to empty.
// ----------------------------------------------------------------------------
`include "sstv_vis_header_detector_assert.svh"

module sstv_vis_header_detector
   import svhd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   svhd_req_if.sink              req_ch,
   svhd_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  csr_idx_type           csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REF,
      ST_SCAN,
      ST_JUDGE,
      ST_DONE
   } state_type;

   state_type                 state_ff;
   step_type                  step_ff;
   tone_type                  ref_ff [NUM_REFS];
   logic                      rsp_valid_ff;
   logic                      rsp_detected_ff;
   code_type                  rsp_code_ff;
   logic signed [SHIFT_W-1:0] rsp_shift_ff;

   logic [CSR_DATA_W-1:0] known_low_ff;
   logic [CSR_DATA_W-1:0] known_high_ff;
   code_type              inv_code_ff;

   logic         req_accept;
   logic         rsp_load;
   tone_type     new_tone;
   cell_ctl_type cell_ctl;
   lane_ctl_type lane_ctl;
   triad_type    cell_triad [NUM_CELLS];
   logic         lane_pass [NUM_LANES];
   code_type     lane_code [NUM_LANES];

   logic     sel_found;
   code_type sel_code;
   tone_type sel_ref;
   diff_type shift_off;
   diff_type shift_adj;
   diff_type shift_q;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign rsp_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   assign new_tone     = req_ch.peak_valid ? req_ch.tone_freq
                                           : cell_triad[NUM_CELLS-1][TRIAD-1];

   assign cell_ctl.shift  = req_accept;
   assign cell_ctl.rotate = (state_ff == ST_REF) || (state_ff == ST_SCAN);

   assign lane_ctl.clear = (state_ff == ST_REF);
   assign lane_ctl.check = (state_ff == ST_SCAN);
   assign lane_ctl.judge = (state_ff == ST_JUDGE);
   assign lane_ctl.step  = step_ff;

   for (genvar gc = 0; gc < NUM_CELLS; gc++) begin : g_cell
      tone_type cell_shift_in;
      if (gc == NUM_CELLS - 1) begin : g_tail
         assign cell_shift_in = new_tone;
      end else begin : g_body
         assign cell_shift_in = cell_triad[gc+1][0];
      end
      svhd_triad u_triad (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .nbr_triad (cell_triad[(gc + 1) % NUM_CELLS]),
         .shift_in  (cell_shift_in),
         .triad     (cell_triad[gc])
      );
   end

   for (genvar gp = 0; gp < NUM_PHASES; gp++) begin : g_phase
      for (genvar gj = 0; gj < NUM_REFS; gj++) begin : g_ref
         svhd_lane u_lane (
            .clock       (clock),
            .reset       (reset),
            .ctl         (lane_ctl),
            .tone        (cell_triad[0][gp]),
            .ref_tone    (ref_ff[gj]),
            .known_codes ({known_high_ff, known_low_ff}),
            .inv_code    (inv_code_ff),
            .pass        (lane_pass[gp*NUM_REFS+gj]),
            .code        (lane_code[gp*NUM_REFS+gj])
         );
      end
   end

   always_comb begin
      sel_found = 1'b0;
      sel_code  = '0;
      sel_ref   = '0;
      for (int p = NUM_PHASES - 1; p >= 0; p--) begin
         for (int j = NUM_REFS - 1; j >= 0; j--) begin
            if (lane_pass[p*NUM_REFS+j]) begin
               sel_found = 1'b1;
               sel_code  = lane_code[p*NUM_REFS+j];
               sel_ref   = ref_ff[j];
            end
         end
      end
   end

   assign shift_off = diff_type'({1'b0, sel_ref}) - CENTER;
   assign shift_adj = shift_off + (shift_off[DIFF_W-1] ? ROUND_UP : diff_type'(0));
   assign shift_q   = shift_adj >>> FREQ_FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         known_low_ff  <= '0;
         known_high_ff <= '0;
         inv_code_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KNOWN_LOW:  known_low_ff  <= csr_wdata;
            CSR_KNOWN_HIGH: known_high_ff <= csr_wdata;
            CSR_INV_PARITY: inv_code_ff   <= csr_wdata[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         step_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         rsp_detected_ff <= 1'b0;
         rsp_code_ff     <= '0;
         rsp_shift_ff    <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_REF;
               end
            end
            ST_REF: begin
               for (int j = 0; j < NUM_REFS; j++) begin
                  ref_ff[j] <= cell_triad[0][j];
               end
               step_ff  <= STEP_FIRST;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               step_ff <= step_ff + step_type'(1);
               if (step_ff == STEP_STOP) begin
                  state_ff <= ST_JUDGE;
               end
            end
            ST_JUDGE: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_detected_ff <= sel_found;
                  rsp_code_ff     <= sel_found ? sel_code : code_type'(0);
                  rsp_shift_ff    <= sel_found ? shift_q[SHIFT_W-1:0] : '0;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.detected   = rsp_detected_ff;
   assign rsp_ch.vis_code   = rsp_code_ff;
   assign rsp_ch.freq_shift = rsp_shift_ff;

   `SVHD_ASSERT_NXT(a_accept_starts_search, clock, reset,
      req_accept, state_ff == ST_REF)
   `SVHD_ASSERT_IMP(a_result_from_done, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)
   `SVHD_ASSERT_IMP(a_empty_result_zero, clock, reset,
      rsp_valid_ff && !rsp_detected_ff, rsp_code_ff == '0 && rsp_shift_ff == '0)
   `SVHD_ASSERT_IMP(a_scan_step_range, clock, reset,
      state_ff == ST_SCAN, step_ff >= STEP_FIRST && step_ff <= STEP_STOP)
   `SVHD_ASSERT_IMP(a_judge_after_stop, clock, reset,
      state_ff == ST_JUDGE, $past(state_ff) == ST_SCAN && $past(step_ff) == STEP_STOP)

endmodule

>>> tb/vis_header_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// VIS header detector result checker
// Mirrors the tone history and register writes, predicts the result of every
// accepted tone transaction and compares each response field in order.
// ----------------------------------------------------------------------------
module vis_header_checker
   import svhd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   svhd_req_if                   req_ch,
   svhd_rsp_if                   rsp_ch,
   input  logic                  csr_wr_en,
   input  csr_idx_type           csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    pending,
   output int                    fail_count
);

   typedef struct packed {
      logic                      detected;
      code_type                  vis_code;
      logic signed [SHIFT_W-1:0] freq_shift;
   } vis_result_type;

   tone_type           tone_ring [HISTORY_DEPTH];
   int unsigned        ring_head;
   logic [KNOWN_W-1:0] known_codes;
   code_type           inverted_code;
   vis_result_type     vis_results_q [$];
   vis_result_type     observed;
   vis_result_type     predicted;

   function automatic logic in_window(longint delta, longint lo_hz, longint hi_hz);
      return (delta > lo_hz * HZ) && (delta < hi_hz * HZ);
   endfunction

   function automatic vis_result_type decode_vis_header(logic peak, tone_type freq);
      longint         tone [HISTORY_DEPTH];
      longint         lead;
      longint         delta;
      logic [7:0]     bits;
      logic           match;
      logic           parity;
      vis_result_type res;
      res = '0;
      if (peak)
         tone_ring[ring_head] = freq;
      else
         tone_ring[ring_head] = tone_ring[(ring_head + HISTORY_DEPTH - 1) % HISTORY_DEPTH];
      ring_head = (ring_head + 1) % HISTORY_DEPTH;
      for (int k = 0; k < HISTORY_DEPTH; k++)
         tone[k] = longint'(tone_ring[(ring_head + k) % HISTORY_DEPTH]);
      for (int p = 0; p < NUM_PHASES && !res.detected; p++) begin
         for (int j = 0; j < NUM_REFS && !res.detected; j++) begin
            lead  = tone[j];
            bits  = '0;
            match = 1'b1;
            for (int k = 1; k <= 4; k++)
               if (!in_window(tone[3*k+p] - lead, -25, 25))
                  match = 1'b0;
            if (!in_window(tone[15+p] - lead, -725, -675))
               match = 1'b0;
            if (!in_window(tone[42+p] - lead, -725, -675))
               match = 1'b0;
            for (int k = 0; k < 8 && match; k++) begin
               delta = tone[18+p+3*k] - lead;
               if (in_window(delta, -825, -775))
                  bits[k] = 1'b1;
               else if (!in_window(delta, -625, -575))
                  match = 1'b0;
            end
            parity = ^bits[6:0] ^ (bits[6:0] == inverted_code);
            if (match && parity == bits[7] && known_codes[bits[6:0]]) begin
               res.detected   = 1'b1;
               res.vis_code   = bits[6:0];
               res.freq_shift = SHIFT_W'((lead - 1900 * HZ) / HZ);
            end
         end
      end
      return res;
   endfunction

   task automatic note_mismatch(string what, vis_result_type want, vis_result_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%t mismatch (%s): expected %0b/%0d/%0d, got %0b/%0d/%0d",
                  $time, what, want.detected, want.vis_code, want.freq_shift,
                  got.detected, got.vis_code, got.freq_shift);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (tone_ring[k])
            tone_ring[k] = '0;
         ring_head     = 0;
         known_codes   = '0;
         inverted_code = '0;
         vis_results_q.delete();
         pending       = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_KNOWN_LOW:  known_codes[CSR_DATA_W-1:0] = csr_wdata;
               CSR_KNOWN_HIGH: known_codes[KNOWN_W-1:CSR_DATA_W] = csr_wdata;
               CSR_INV_PARITY: inverted_code = csr_wdata[CODE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            observed = '{rsp_ch.detected, rsp_ch.vis_code, rsp_ch.freq_shift};
            if (vis_results_q.size() == 0) begin
               note_mismatch("no transaction outstanding", '0, observed);
            end else begin
               predicted = vis_results_q.pop_front();
               if (observed.detected !== predicted.detected ||
                   observed.vis_code !== predicted.vis_code ||
                   observed.freq_shift !== predicted.freq_shift)
                  note_mismatch("result fields", predicted, observed);
            end
         end
         if (req_ch.valid && req_ch.ready)
            vis_results_q.push_back(decode_vis_header(req_ch.peak_valid, req_ch.tone_freq));
         pending = vis_results_q.size();
      end
   end

endmodule

>>> tb/sstv_vis_header_detector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SSTV VIS header detector testbench
// Feeds tone estimates built as whole or broken calibration headers with
// random codes, jitter and window-edge tones, plus noise, under several
// register settings and sender/receiver idle patterns; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module sstv_vis_header_detector_tb;
   import svhd_pkg::*;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum int {
      HDR_CLEAN, HDR_SHIFT_ZERO, HDR_INV_PARITY, HDR_BAD_PARITY,
      HDR_UNKNOWN_CODE, HDR_BAD_BIT, HDR_EDGE
   } header_kind_type;

   localparam int ITEMS_PER_PHASE = 30;
   localparam int PAUSE_ITEM      = 150;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   csr_idx_type           csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    pending;
   int                    fail_count;
   int                    send_idle_pct;
   int                    recv_stall_pct;
   int                    item_count;
   logic [KNOWN_W-1:0]    known_cfg;
   code_type              inv_cfg;

   svhd_req_if req_ch ();
   svhd_rsp_if rsp_ch ();

   sstv_vis_header_detector u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   vis_header_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .fail_count (fail_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_tone(logic peak, tone_type freq);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 30) : 0;
      if (item_count == PAUSE_ITEM || $urandom_range(249) == 0) begin
         wait_drained();
      end else if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.peak_valid <= peak;
      req_ch.tone_freq  <= freq;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      item_count++;
   endtask

   task automatic program_registers(logic [CSR_DATA_W-1:0] lo_mask,
                                    logic [CSR_DATA_W-1:0] hi_mask, code_type inv);
      known_cfg = {hi_mask, lo_mask};
      inv_cfg   = inv;
      csr_wr_en <= 1'b1;
      csr_index <= CSR_KNOWN_LOW;
      csr_wdata <= lo_mask;
      @(posedge clock);
      csr_index <= CSR_KNOWN_HIGH;
      csr_wdata <= hi_mask;
      @(posedge clock);
      csr_index <= CSR_INV_PARITY;
      csr_wdata <= CSR_DATA_W'(inv);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Triads 0-4 leader, 5 start, 6-13 code bits LSB first, 14 stop.
   task automatic send_header(header_kind_type kind, int length);
      longint     base;
      longint     level [15];
      logic       exact [15];
      logic [7:0] bits;
      code_type   code;
      int         slot;
      int         lo_hz;
      int         hi_hz;
      logic       lower;
      int         tries;
      longint     value;
      if ($urandom_range(3) != 0)
         base = 1700 * HZ + longint'($urandom_range(0, 400 * HZ));
      else
         base = longint'($urandom_range(830 * HZ, 32000 * HZ));
      if (kind == HDR_SHIFT_ZERO)
         base = 1900 * HZ;
      code = code_type'($urandom_range(127));
      if (kind == HDR_INV_PARITY)
         code = inv_cfg;
      else
         for (tries = 0; tries < 40 && known_cfg[code] == (kind == HDR_UNKNOWN_CODE); tries++)
            code = code_type'($urandom_range(127));
      bits = {^code ^ (code == inv_cfg) ^ (kind == HDR_BAD_PARITY), code};
      for (int t = 0; t < 15; t++) begin
         exact[t] = 1'b0;
         level[t] = base;
      end
      level[5]  = base - 700 * HZ;
      level[14] = base - 700 * HZ;
      for (int k = 0; k < 8; k++)
         level[6+k] = base - (bits[k] ? 800 : 600) * HZ;
      if (kind == HDR_SHIFT_ZERO || kind == HDR_EDGE)
         exact[0] = 1'b1;
      if (kind == HDR_BAD_BIT)
         level[6 + $urandom_range(7)] = base - 700 * HZ;
      if (kind == HDR_EDGE) begin
         slot = $urandom_range(1, 14);
         if (slot <= 4) begin
            lo_hz = -25;
            hi_hz = 25;
         end else if (slot == 5 || slot == 14) begin
            lo_hz = -725;
            hi_hz = -675;
         end else if (bits[slot-6]) begin
            lo_hz = -825;
            hi_hz = -775;
         end else begin
            lo_hz = -625;
            hi_hz = -575;
         end
         lower       = 1'($urandom_range(1));
         level[slot] = base + (lower ? lo_hz : hi_hz) * HZ;
         // nudge one step inside the window half the time
         if ($urandom_range(1) != 0)
            level[slot] += lower ? 1 : -1;
         exact[slot] = 1'b1;
      end
      for (int n = 0; n < length; n++) begin
         value = level[n/3];
         if (!exact[n/3])
            value += longint'($urandom_range(0, 16 * HZ)) - 8 * HZ;
         if (n % 3 != 0 && $urandom_range(99) < 30)
            send_tone(1'b0, tone_type'($urandom));
         else
            send_tone(1'b1, tone_type'(value));
      end
   endtask

   task automatic run_phase(logic [CSR_DATA_W-1:0] lo_mask, logic [CSR_DATA_W-1:0] hi_mask,
                            code_type inv, idle_mode_type mode, logic lead_in);
      int              phase_end;
      int              pick;
      header_kind_type kind;
      wait_drained();
      case (mode)
         IDLE_SENDER: begin
            send_idle_pct  = 69;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = 69;
         end
         IDLE_BOTH: begin
            send_idle_pct  = 22;
            recv_stall_pct = 22;
         end
         default: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
      endcase
      program_registers(lo_mask, hi_mask, inv);
      phase_end = item_count + ITEMS_PER_PHASE;
      if (lead_in) begin
         // no peak right after reset repeats the cleared entry
         send_tone(1'b0, 19'h7FFFF);
         send_tone(1'b1, 19'h7FFFF);
         send_tone(1'b0, 19'h00000);
         send_tone(1'b1, 19'h00000);
         send_tone(1'b1, 19'h2AAAA);
         send_tone(1'b1, 19'h55555);
         send_tone(1'b0, 19'h2AAAA);
         send_tone(1'b1, tone_type'(1900 * HZ));
         for (int k = HDR_SHIFT_ZERO; k <= HDR_EDGE; k++)
            send_header(header_kind_type'(k), 45);
      end
      while (item_count < phase_end) begin
         pick = $urandom_range(99);
         if (pick < 45)
            kind = HDR_CLEAN;
         else if (pick < 55)
            kind = HDR_SHIFT_ZERO;
         else if (pick < 65)
            kind = HDR_INV_PARITY;
         else if (pick < 72)
            kind = HDR_BAD_PARITY;
         else if (pick < 79)
            kind = HDR_UNKNOWN_CODE;
         else if (pick < 86)
            kind = HDR_BAD_BIT;
         else
            kind = HDR_EDGE;
         pick = $urandom_range(99);
         if (pick < 75)
            send_header(kind, 45);
         else if (pick < 88)
            repeat ($urandom_range(1, 8)) send_tone(1'($urandom_range(1)), tone_type'($urandom));
         else
            send_header(kind, $urandom_range(4, 44));
      end
   endtask

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.peak_valid = 1'b0;
      req_ch.tone_freq  = '0;
      rsp_ch.ready      = 1'b0;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_KNOWN_LOW;
      csr_wdata         = '0;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      item_count        = 0;
      known_cfg         = '0;
      inv_cfg           = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      run_phase('1, '1, 7'h7F, IDLE_NONE, 1'b1);
      run_phase('0, '0, 7'h00, IDLE_SENDER, 1'b0);
      run_phase({$urandom, $urandom}, {$urandom, $urandom}, code_type'($urandom),
                IDLE_RECEIVER, 1'b0);
      run_phase('1, '0, code_type'($urandom), IDLE_BOTH, 1'b0);
      run_phase('0, '1, code_type'($urandom), IDLE_NONE, 1'b0);
      run_phase({$urandom, $urandom}, {$urandom, $urandom}, 7'h00, IDLE_SENDER, 1'b0);
      run_phase({$urandom, $urandom}, {$urandom, $urandom}, code_type'($urandom),
                IDLE_BOTH, 1'b0);
      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/svhd_pkg.sv
hw/rtl/svhd_req_if.sv
hw/rtl/svhd_rsp_if.sv
hw/rtl/svhd_triad.sv
hw/rtl/svhd_lane.sv
hw/rtl/sstv_vis_header_detector.sv
tb/vis_header_checker.sv
tb/sstv_vis_header_detector_tb.sv
